// ===== sv/gasf_pkg.sv =====
package gasf_pkg;

    localparam int MAX_LEN = 256;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SYM_W   = 8;
    localparam int CFG_W   = 8;
    localparam int SCORE_W = 18;
    localparam int WIDE_W  = SCORE_W + 2;

    localparam int ACT_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [ACT_W-1:0] ACT_COL_LOAD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ROW_LOAD = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXT  = 2'd3;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic signed [CFG_W-1:0]   t_cfg;

    // Clamp a widened score back into the stored score range.
    function automatic t_score sat_score(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = WIDE_W'(SCORE_MAX);
        lo = WIDE_W'(SCORE_MIN);
        if (v > hi) begin
            return SCORE_MAX;
        end else if (v < lo) begin
            return SCORE_MIN;
        end else begin
            return v[SCORE_W-1:0];
        end
    endfunction

endpackage

// ===== sv/gasf_ram.sv =====
module gasf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/global_alignment_score_fill.sv =====
// Load and clear items keep the FSM idle; the block is ready again on the next cycle.
// For C column and R row symbols, compute fills the top row, then gives each row
// a row-start step and C cells, one cell per cycle through one shared cell unit.
// The result then sits in an output register until taken; loads continue meanwhile.
// Synchronous active-low reset clears lengths, overflow flag, result valid and FSM;
// input ready stays low during reset. Symbol and score memories are never cleared.
module global_alignment_score_fill
    import gasf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] symbol
    input  logic [ACT_W-1:0]       i_s_axis_tuser,  // [1:0] action
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // [17:0] final_score, rest zero
    output logic [0:0]             o_m_axis_tuser   // [0] length_overflow
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TOP  = 3'd1;
    localparam logic [2:0] S_ROWS = 3'd2;
    localparam logic [2:0] S_CELL = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_state;
    t_cfg             r_match;
    t_cfg             r_mismatch;
    t_cfg             r_gap_open;
    t_cfg             r_gap_ext;
    logic [LEN_W-1:0] r_col_len;
    logic [LEN_W-1:0] r_row_len;
    logic             r_overflow;
    logic [LEN_W-1:0] r_col;
    logic [LEN_W-1:0] r_row;
    t_score           r_acc;
    t_score           r_edge;
    t_score           r_diag;
    t_score           r_left;
    logic             r_row_mark;
    t_score           r_result;
    logic             r_out_valid;
    t_score           r_out_score;
    logic             r_out_ovf;

    logic             in_xfer;
    logic [SYM_W-1:0] in_sym;
    logic [ACT_W-1:0] in_act;
    logic             col_we;
    logic             row_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic             score_we;
    logic [SCORE_W:0] score_wdata;
    logic [SCORE_W:0] score_rdata;
    logic [SYM_W-1:0] col_rdata;
    logic [SYM_W-1:0] row_rdata;

    t_score n_top;
    t_score n_edge;
    t_score n_cell;
    logic   n_row_mark;
    logic   n_col_mark;
    t_score up_score;
    logic   up_mark;
    t_wide  w_cd;
    t_wide  w_cl;
    t_wide  w_cu;

    assign o_s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign in_sym  = i_s_axis_tdata[SYM_W-1:0];
    assign in_act  = i_s_axis_tuser;

    assign col_we = in_xfer && (in_act == ACT_COL_LOAD) && (r_col_len < LEN_W'(MAX_LEN));
    assign row_we = in_xfer && (in_act == ACT_ROW_LOAD) && (r_row_len < LEN_W'(MAX_LEN));

    // score memory holds columns 1..C at address c-1; column 0 lives in r_edge
    assign wr_addr  = ADDR_W'(r_col - 1'b1);
    assign rd_addr  = (r_state == S_CELL) ? r_col[ADDR_W-1:0] : '0;
    assign score_we = (r_state == S_TOP) || (r_state == S_CELL);
    assign score_wdata = (r_state == S_TOP) ? {1'b0, n_top} : {n_col_mark, n_cell};

    gasf_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_col_len[ADDR_W-1:0]),
        .i_wdata (in_sym),
        .i_raddr (rd_addr),
        .o_rdata (col_rdata)
    );

    gasf_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_row_len[ADDR_W-1:0]),
        .i_wdata (in_sym),
        .i_raddr (r_row[ADDR_W-1:0]),
        .o_rdata (row_rdata)
    );

    gasf_ram #(.WIDTH(SCORE_W + 1), .DEPTH(MAX_LEN)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (score_we),
        .i_waddr (wr_addr),
        .i_wdata (score_wdata),
        .i_raddr (rd_addr),
        .o_rdata (score_rdata)
    );

    assign up_score = score_rdata[SCORE_W-1:0];
    assign up_mark  = score_rdata[SCORE_W];

    // boundary steps: open on the first step, extend after
    assign n_top  = sat_score(WIDE_W'(r_acc)
                    - WIDE_W'((r_col == LEN_W'(1)) ? r_gap_open : r_gap_ext));
    assign n_edge = sat_score(WIDE_W'(r_edge)
                    - WIDE_W'((r_row == '0) ? r_gap_open : r_gap_ext));

    // shared cell unit
    assign w_cd = WIDE_W'(r_diag) - WIDE_W'(r_mismatch);
    assign w_cl = WIDE_W'(r_left) - WIDE_W'(r_row_mark ? r_gap_ext : r_gap_open);
    assign w_cu = WIDE_W'(up_score) - WIDE_W'(up_mark ? r_gap_ext : r_gap_open);

    always_comb begin
        if (row_rdata == col_rdata) begin
            n_cell     = sat_score(WIDE_W'(r_diag) + WIDE_W'(r_match));
            n_row_mark = 1'b0;
            n_col_mark = 1'b0;
        end else if ((w_cd >= w_cl) && (w_cd >= w_cu)) begin
            n_cell     = sat_score(w_cd);
            n_row_mark = 1'b0;
            n_col_mark = 1'b0;
        end else if (w_cl >= w_cu) begin
            n_cell     = sat_score(w_cl);
            n_row_mark = 1'b1;
            n_col_mark = 1'b0;
        end else begin
            n_cell     = sat_score(w_cu);
            n_row_mark = 1'b0;
            n_col_mark = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= CFG_W'(1);
            r_mismatch <= '1;
            r_gap_open <= CFG_W'(1);
            r_gap_ext  <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MATCH:    r_match    <= i_cfg_data;
                CFG_MISMATCH: r_mismatch <= i_cfg_data;
                CFG_GAP_OPEN: r_gap_open <= i_cfg_data;
                CFG_GAP_EXT:  r_gap_ext  <= i_cfg_data;
                default:      r_match    <= r_match;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col_len   <= '0;
            r_row_len   <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result loaded in S_DONE takes the place of the one leaving
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        unique case (in_act)
                            ACT_COL_LOAD: begin
                                if (col_we) begin
                                    r_col_len <= r_col_len + 1'b1;
                                end else begin
                                    r_overflow <= 1'b1;
                                end
                            end
                            ACT_ROW_LOAD: begin
                                if (row_we) begin
                                    r_row_len <= r_row_len + 1'b1;
                                end else begin
                                    r_overflow <= 1'b1;
                                end
                            end
                            ACT_COMPUTE: begin
                                r_col    <= LEN_W'(1);
                                r_row    <= '0;
                                r_acc    <= '0;
                                r_edge   <= '0;
                                r_result <= '0;
                                r_state  <= (r_col_len == '0) ? S_ROWS : S_TOP;
                            end
                            default: begin
                                r_col_len  <= '0;
                                r_row_len  <= '0;
                                r_overflow <= 1'b0;
                            end
                        endcase
                    end
                end
                S_TOP: begin
                    r_acc    <= n_top;
                    r_result <= n_top;
                    if (r_col == r_col_len) begin
                        r_state <= S_ROWS;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_ROWS: begin
                    if (r_row == r_row_len) begin
                        r_state <= S_DONE;
                    end else begin
                        r_diag     <= r_edge;
                        r_edge     <= n_edge;
                        r_left     <= n_edge;
                        r_row_mark <= 1'b0;
                        r_col      <= LEN_W'(1);
                        if (r_col_len == '0) begin
                            r_result <= n_edge;
                            r_row    <= r_row + 1'b1;
                        end else begin
                            r_state <= S_CELL;
                        end
                    end
                end
                S_CELL: begin
                    r_diag     <= up_score;
                    r_left     <= n_cell;
                    r_row_mark <= n_row_mark;
                    if (r_col == r_col_len) begin
                        r_result <= n_cell;
                        r_row    <= r_row + 1'b1;
                        r_state  <= S_ROWS;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_DONE: begin
                    // wait for the output register to drain
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_score <= r_result;
                        r_out_ovf   <= r_overflow;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - SCORE_W){1'b0}}, r_out_score};
    assign o_m_axis_tuser  = r_out_ovf;

endmodule

// ===== sv/gasf_checker.sv =====
module gasf_checker
    import gasf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [ACT_W-1:0]       i_s_axis_tuser,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]             o_m_axis_tuser
);

    logic in_xfer;
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_s_axis_tuser == ACT_COMPUTE) |=> !o_s_axis_tready)
        else $error("ready right after compute transfer");

    a_load_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_s_axis_tuser != ACT_COMPUTE) |=> o_s_axis_tready)
        else $error("not ready after load or clear");

    a_result_ends_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $rose(o_s_axis_tready))
        else $error("result appeared outside end of compute");

endmodule

bind global_alignment_score_fill gasf_checker u_gasf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
